// ===== src/can_tx_queue_with_timeout_macros.svh =====
// Assertion macros for the CAN transmit queue
`ifndef CAN_TX_QUEUE_WITH_TIMEOUT_MACROS_SVH
`define CAN_TX_QUEUE_WITH_TIMEOUT_MACROS_SVH
`ifndef ASSERT_OFF
`define CTQ_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CTQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CTQ_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define CTQ_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/ctq_pkg.sv =====
// Shared types and constants for the CAN transmit queue
`default_nettype none
package ctq_pkg;
    localparam logic [2:0] OP_ENQ = 3'd0;
    localparam logic [2:0] OP_TICK = 3'd1;
    localparam logic [2:0] OP_DONE = 3'd2;
    localparam logic [2:0] OP_ERR = 3'd3;
    localparam logic [2:0] OP_RREQ = 3'd4;
    localparam logic [2:0] OP_RREP = 3'd5;

    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_ABORT = 3'd1;
    localparam logic [2:0] ACT_RAISE = 3'd2;
    localparam logic [2:0] ACT_ENQ = 3'd3;
    localparam logic [2:0] ACT_DROP = 3'd4;

    localparam logic [1:0] REG_ID_HIGH = 2'd0;
    localparam logic [1:0] REG_ID_LOW = 2'd1;
    localparam logic [1:0] REG_HIKE = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    localparam logic [15:0] HIKE_RESET = 16'd750;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0] PRIO_BITS = 8'hC0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        STEP_ENQ,
        STEP_CHECK,
        STEP_START,
        STEP_DONE,
        STEP_ERR,
        STEP_REMOTE,
        STEP_NONE
    } step_t;

    typedef struct packed {
        logic  load;
        logic  exec;
        step_t step;
        logic [1:0] idx;
    } ctq_cmd_t;

    typedef struct packed {
        logic  emit;
        logic  more;
    } ctq_sts_t;
endpackage
`default_nettype wire

// ===== src/ctq_ram.sv =====
// Generic RAM with one write port, one read port and registered read
`default_nettype none
module ctq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/ctq_ctrl.sv =====
// Sequencer that steps one input word through its results
`default_nettype none
module ctq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [2:0]       opcode,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  out_last,
    output ctq_pkg::ctq_cmd_t     cmd,
    input  wire ctq_pkg::ctq_sts_t sts
);
    ctq_pkg::state_t state_reg, state_next;
    ctq_pkg::step_t  step_reg, step_next;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] op_reg, op_next;
    logic       last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctq_pkg::ST_IDLE;
            step_reg  <= ctq_pkg::STEP_NONE;
            idx_reg   <= 2'd0;
            op_reg    <= 3'd0;
            out_last  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            op_reg    <= op_next;
            if (cmd.exec && sts.emit)
            begin
                out_last <= !sts.more;
            end
        end
    end

    // choose the step that follows the current one
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        last_next  = 1'b1;
        case (state_reg)
            ctq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    idx_next   = 2'd0;
                    state_next = ctq_pkg::ST_READ;
                    case (opcode)
                        ctq_pkg::OP_ENQ:  step_next = ctq_pkg::STEP_ENQ;
                        ctq_pkg::OP_TICK: step_next = ctq_pkg::STEP_CHECK;
                        ctq_pkg::OP_DONE: step_next = ctq_pkg::STEP_DONE;
                        ctq_pkg::OP_ERR:  step_next = ctq_pkg::STEP_ERR;
                        ctq_pkg::OP_RREQ: step_next = ctq_pkg::STEP_REMOTE;
                        ctq_pkg::OP_RREP: step_next = ctq_pkg::STEP_REMOTE;
                        default:
                        begin
                            step_next  = ctq_pkg::STEP_NONE;
                            state_next = ctq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ctq_pkg::ST_READ:
            begin
                state_next = ctq_pkg::ST_EXEC;
            end
            ctq_pkg::ST_EXEC:
            begin
                case (step_reg)
                    ctq_pkg::STEP_CHECK:
                    begin
                        if (idx_reg == 2'd0)
                        begin
                            step_next = ctq_pkg::STEP_START;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                        last_next = (idx_reg == 2'd2);
                    end
                    ctq_pkg::STEP_START:
                    begin
                        step_next = ctq_pkg::STEP_CHECK;
                        idx_next  = 2'd1;
                        last_next = 1'b0;
                    end
                    ctq_pkg::STEP_ERR:
                    begin
                        idx_next  = idx_reg + 2'd1;
                        last_next = (idx_reg == 2'd2);
                    end
                    default:
                    begin
                        last_next = 1'b1;
                    end
                endcase
                if (sts.emit)
                begin
                    state_next = ctq_pkg::ST_OUT;
                end
                else if (last_next)
                begin
                    state_next = ctq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = ctq_pkg::ST_READ;
                end
                if (sts.emit && last_next)
                begin
                    step_next = ctq_pkg::STEP_NONE;
                end
            end
            ctq_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = (step_reg == ctq_pkg::STEP_NONE) ?
                                 ctq_pkg::ST_IDLE : ctq_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = ctq_pkg::ST_IDLE;
            end
        endcase
    end

    // drive handshake and datapath commands
    always_comb
    begin
        in_ready  = (state_reg == ctq_pkg::ST_IDLE);
        out_valid = (state_reg == ctq_pkg::ST_OUT);
        cmd.load  = (state_reg == ctq_pkg::ST_IDLE) && in_valid;
        cmd.exec  = (state_reg == ctq_pkg::ST_EXEC);
        cmd.step  = step_reg;
        cmd.idx   = idx_reg;
        if (op_reg == ctq_pkg::OP_RREP && step_reg == ctq_pkg::STEP_REMOTE)
        begin
            cmd.idx = 2'd2;
        end
        else if (step_reg == ctq_pkg::STEP_REMOTE)
        begin
            cmd.idx = 2'd1;
        end
    end
endmodule
`default_nettype wire

// ===== src/ctq_dp.sv =====
// Queue, buffer timers and result register
`default_nettype none
module ctq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic [2:0]         buffer_mask,
    input  wire logic [63:0]        message_bytes,
    input  wire ctq_pkg::ctq_cmd_t  cmd,
    output ctq_pkg::ctq_sts_t       sts,
    output logic [2:0]              action,
    output logic [1:0]              buffer,
    output logic [7:0]              frame_id_high,
    output logic [7:0]              frame_id_low,
    output logic [3:0]              length,
    output logic                    remote_flag,
    output logic [63:0]             frame_data,
    output logic [4:0]              queue_level
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int PW = AW + 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]  id_high_reg, id_low_reg;
    logic [15:0] hike_reg, timeout_reg, ms_reg;
    logic [PW-1:0] head_reg, tail_reg;
    logic [2:0]  pend_reg;
    logic [15:0] st_reg [3];
    logic [7:0]  bid_reg [3];
    logic [2:0]  mask_reg;
    logic [63:0] msg_reg;
    logic [63:0] rdata;
    logic [PW-1:0] lvl, lvl_after;
    logic        full, nonempty;
    logic        first_chk;
    logic [15:0] ms_eff;
    logic [15:0] age, age1, age2;
    logic        fire1, fire2, start_will, more;
    logic        emit;
    logic [2:0]  act;
    logic [7:0]  idh;
    logic [3:0]  len;
    logic [63:0] dat;
    logic        rem;
    logic        enq_we;

    assign lvl      = tail_reg - head_reg;
    assign full     = (lvl == PW'(QUEUE_DEPTH));
    assign nonempty = (lvl != '0);
    assign enq_we   = cmd.exec && (cmd.step == ctq_pkg::STEP_ENQ) && !full;
    // the first tick check sees the advanced count
    assign first_chk = (cmd.step == ctq_pkg::STEP_CHECK) && (cmd.idx == 2'd0);
    assign ms_eff   = ms_reg + {15'd0, first_chk};
    assign age      = ms_eff - st_reg[cmd.idx];
    assign age1     = ms_eff - st_reg[1];
    assign age2     = ms_eff - st_reg[2];
    assign fire1    = pend_reg[1] &&
                      ((((bid_reg[1] & ctq_pkg::PRIO_BITS) != 8'd0) && age1 >= hike_reg) ||
                       age1 >= timeout_reg);
    assign fire2    = pend_reg[2] &&
                      ((((bid_reg[2] & ctq_pkg::PRIO_BITS) != 8'd0) && age2 >= hike_reg) ||
                       age2 >= timeout_reg);
    assign start_will = nonempty && (!pend_reg[0] || (emit && act == ctq_pkg::ACT_ABORT));
    assign sts.emit = emit;
    assign sts.more = more;

    ctq_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (enq_we),
        .waddr (tail_reg[AW-1:0]),
        .wdata (msg_reg),
        .raddr (head_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        emit = 1'b0;
        act  = ctq_pkg::ACT_ENQ;
        idh  = 8'd0;
        len  = 4'd0;
        dat  = 64'd0;
        rem  = 1'b0;
        case (cmd.step)
            ctq_pkg::STEP_ENQ:
            begin
                emit = 1'b1;
                act  = full ? ctq_pkg::ACT_DROP : ctq_pkg::ACT_ENQ;
            end
            ctq_pkg::STEP_CHECK:
            begin
                idh = bid_reg[cmd.idx];
                if (pend_reg[cmd.idx])
                begin
                    if (((bid_reg[cmd.idx] & ctq_pkg::PRIO_BITS) != 8'd0) && age >= hike_reg)
                    begin
                        emit = 1'b1;
                        act  = ctq_pkg::ACT_RAISE;
                        idh  = bid_reg[cmd.idx] & ~ctq_pkg::PRIO_BITS;
                    end
                    else if (age >= timeout_reg)
                    begin
                        emit = 1'b1;
                        act  = ctq_pkg::ACT_ABORT;
                    end
                end
            end
            ctq_pkg::STEP_START, ctq_pkg::STEP_DONE:
            begin
                idh  = id_high_reg;
                len  = {1'b0, rdata[7:5]} + 4'd1;
                act  = ctq_pkg::ACT_START;
                emit = nonempty && (cmd.step == ctq_pkg::STEP_DONE ? mask_reg[0] : !pend_reg[0]);
                for (int b = 0; b < 8; b++)
                begin
                    dat[8*b +: 8] = (4'(b) < len) ? rdata[8*b +: 8] : 8'd0;
                end
            end
            ctq_pkg::STEP_ERR:
            begin
                idh  = bid_reg[cmd.idx];
                act  = ctq_pkg::ACT_ABORT;
                emit = mask_reg[cmd.idx] && pend_reg[cmd.idx];
            end
            ctq_pkg::STEP_REMOTE:
            begin
                idh  = id_high_reg;
                act  = ctq_pkg::ACT_START;
                emit = 1'b1;
                rem  = (cmd.idx == 2'd1);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // look ahead for a later result of the same word
    always_comb
    begin
        more = 1'b0;
        case (cmd.step)
            ctq_pkg::STEP_CHECK:
            begin
                if (cmd.idx == 2'd0)
                begin
                    more = start_will || fire1 || fire2;
                end
                else if (cmd.idx == 2'd1)
                begin
                    more = fire2;
                end
            end
            ctq_pkg::STEP_START:
            begin
                more = fire1 || fire2;
            end
            ctq_pkg::STEP_ERR:
            begin
                if (cmd.idx == 2'd0)
                begin
                    more = |(mask_reg[2:1] & pend_reg[2:1]);
                end
                else if (cmd.idx == 2'd1)
                begin
                    more = mask_reg[2] && pend_reg[2];
                end
            end
            default:
            begin
                more = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        lvl_after = lvl;
        if (enq_we)
        begin
            lvl_after = lvl + PW'(1);
        end
        else if (emit && act == ctq_pkg::ACT_START &&
                 (cmd.step == ctq_pkg::STEP_START || cmd.step == ctq_pkg::STEP_DONE))
        begin
            lvl_after = lvl - PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_high_reg <= 8'd0;
            id_low_reg  <= 8'd0;
            hike_reg    <= ctq_pkg::HIKE_RESET;
            timeout_reg <= ctq_pkg::TIMEOUT_RESET;
            ms_reg      <= 16'd0;
            head_reg    <= '0;
            tail_reg    <= '0;
            pend_reg    <= 3'd0;
            for (int i = 0; i < 3; i++)
            begin
                st_reg[i]  <= 16'd0;
                bid_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ctq_pkg::REG_ID_HIGH: id_high_reg <= cfg_data[7:0];
                    ctq_pkg::REG_ID_LOW:  id_low_reg  <= cfg_data[7:0];
                    ctq_pkg::REG_HIKE:    hike_reg    <= cfg_data;
                    ctq_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                    default:              hike_reg    <= hike_reg;
                endcase
            end
            if (cmd.exec && first_chk)
            begin
                ms_reg <= ms_eff;
            end
            if (enq_we)
            begin
                tail_reg <= tail_reg + PW'(1);
            end
            if (cmd.exec && emit)
            begin
                case (cmd.step)
                    ctq_pkg::STEP_CHECK:
                    begin
                        if (act == ctq_pkg::ACT_RAISE)
                        begin
                            bid_reg[cmd.idx] <= idh;
                        end
                        else
                        begin
                            pend_reg[cmd.idx] <= 1'b0;
                        end
                    end
                    ctq_pkg::STEP_START:
                    begin
                        head_reg    <= head_reg + PW'(1);
                        pend_reg[0] <= 1'b1;
                        st_reg[0]   <= ms_reg;
                        bid_reg[0]  <= id_high_reg;
                    end
                    ctq_pkg::STEP_DONE:
                    begin
                        head_reg    <= head_reg + PW'(1);
                        st_reg[0]   <= ms_reg;
                        bid_reg[0]  <= id_high_reg;
                    end
                    ctq_pkg::STEP_ERR:
                    begin
                        pend_reg[cmd.idx] <= 1'b0;
                    end
                    ctq_pkg::STEP_REMOTE:
                    begin
                        pend_reg[cmd.idx] <= 1'b1;
                        st_reg[cmd.idx]   <= ms_reg;
                        bid_reg[cmd.idx]  <= id_high_reg;
                    end
                    default:
                    begin
                        pend_reg <= pend_reg;
                    end
                endcase
            end
            if (cmd.exec && cmd.step == ctq_pkg::STEP_DONE)
            begin
                pend_reg <= (pend_reg & ~mask_reg) | {2'b00, emit};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mask_reg <= buffer_mask;
            msg_reg  <= message_bytes;
        end
        if (cmd.exec && emit)
        begin
            action        <= act;
            buffer        <= (cmd.step == ctq_pkg::STEP_ENQ) ? 2'd0 : cmd.idx;
            frame_id_high <= idh;
            frame_id_low  <= (cmd.step == ctq_pkg::STEP_ENQ) ? 8'd0 : id_low_reg;
            length        <= len;
            remote_flag   <= rem;
            frame_data    <= dat;
            queue_level   <= 5'(LW'(lvl_after));
        end
    end
endmodule
`default_nettype wire

// ===== src/can_tx_queue_with_timeout.sv =====
// Top level of the CAN transmit queue with timeout
// After an input word is accepted, the read and execute states come before its first result word.
// Each further result passes through the read and execute states again and can be held by output stall;
// a step with no result skips the output state. A tick gives at most four results.
// Reset clears pointers, timers, pending flags and configuration registers to their defaults.
`default_nettype none
`include "can_tx_queue_with_timeout_macros.svh"
module can_tx_queue_with_timeout #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [2:0]  buffer_mask,
    input  wire logic [63:0] message_bytes,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       action,
    output logic [1:0]       buffer,
    output logic [7:0]       frame_id_high,
    output logic [7:0]       frame_id_low,
    output logic [3:0]       length,
    output logic             remote_flag,
    output logic [63:0]      frame_data,
    output logic [4:0]       queue_level,
    output logic             last
);
    ctq_pkg::ctq_cmd_t cmd;
    ctq_pkg::ctq_sts_t sts;

    ctq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (last),
        .cmd       (cmd),
        .sts       (sts)
    );

    ctq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .buffer_mask   (buffer_mask),
        .message_bytes (message_bytes),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .buffer        (buffer),
        .frame_id_high (frame_id_high),
        .frame_id_low  (frame_id_low),
        .length        (length),
        .remote_flag   (remote_flag),
        .frame_data    (frame_data),
        .queue_level   (queue_level)
    );

    `CTQ_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid, "input taken during output")
    `CTQ_ASSERT_NEVER(a_level_range, clk, rst_n, out_valid && queue_level > 5'(QUEUE_DEPTH), "level overflow")
    `CTQ_ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "output dropped")
endmodule
`default_nettype wire
